// File: rtl/khm_pkg.sv
`timescale 1ns / 1ps
package khm_pkg;
  localparam int MAX_RUNS_DEF      = 8;
  localparam int RUN_DEPTH_DEF     = 256;
  localparam int KEY_WIDTH_DEF     = 32;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int RUN_SEL_W         = 3;
  localparam int OUT_W             = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BUILD_SCAN,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_POP_ADV,
    ST_CAT_SKIP,
    ST_OUT
  } khm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic scan_step;
    logic scan_init;
    logic sift_start_build;
    logic sift_start_root;
    logic sift_rd;
    logic sift_cmp;
    logic pop_rd;
    logic pop_adv;
    logic cat_step;
    logic empty_res;
    logic start_merge;
  } khm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_ok;
    logic scan_done;
    logic sift_done;
    logic build_done;
    logic heap_empty;
    logic cat_done;
    logic cat_ok;
    logic mode_cmp;
    logic started;
  } khm_sts_t;
endpackage

// File: rtl/khm_if.sv
`timescale 1ns / 1ps
interface khm_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/khm_ram.sv
`timescale 1ns / 1ps
module khm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/khm_ctrl.sv
`timescale 1ns / 1ps
module khm_ctrl import khm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_cmd,
  input  logic     out_busy,
  output logic     in_ready,
  output logic     res_load,
  output khm_cmd_t cmd,
  input  khm_sts_t sts
);
  khm_state_t state_r, state_nxt;
  logic       from_pop_r, from_pop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      from_pop_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      from_pop_r <= from_pop_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    from_pop_nxt = from_pop_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (!sts.started) begin
            state_nxt = sts.mode_cmp ? ST_BUILD_SCAN : ST_CAT_SKIP;
          end else begin
            state_nxt = sts.mode_cmp ? ST_POP_RD : ST_CAT_SKIP;
          end
          from_pop_nxt = 1'b0;
        end
      end
      ST_LOAD: state_nxt = ST_IDLE;
      ST_BUILD_SCAN: if (sts.scan_done) state_nxt = ST_SIFT_RD;
      ST_SIFT_RD: begin
        if (sts.sift_done) begin
          if (from_pop_r) state_nxt = ST_OUT;
          else if (sts.build_done) state_nxt = ST_POP_RD;
          else state_nxt = ST_SIFT_RD;
        end else begin
          state_nxt = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: state_nxt = ST_SIFT_RD;
      ST_POP_RD: state_nxt = sts.heap_empty ? ST_OUT : ST_POP_WAIT;
      ST_POP_WAIT: state_nxt = ST_POP_ADV;
      ST_POP_ADV: begin
        from_pop_nxt = 1'b1;
        state_nxt    = ST_SIFT_RD;
      end
      ST_CAT_SKIP: if (sts.cat_done) state_nxt = ST_OUT;
      ST_OUT: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_cmd == CMD_PULL && !sts.started) begin
          cmd.start_merge = 1'b1;
          cmd.scan_init   = 1'b1;
        end
      end
      ST_LOAD: cmd.load_wr = 1'b1;
      ST_BUILD_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) cmd.sift_start_build = 1'b1;
      end
      ST_SIFT_RD: begin
        if (!sts.sift_done) cmd.sift_rd = 1'b1;
        else if (!from_pop_r && !sts.build_done) cmd.sift_start_build = 1'b1;
      end
      ST_SIFT_CMP: cmd.sift_cmp = 1'b1;
      ST_POP_RD: cmd.pop_rd = 1'b1;
      // keep the root row address on the read port until it is captured
      ST_POP_WAIT: cmd.pop_rd = 1'b1;
      ST_POP_ADV: begin
        cmd.pop_adv         = 1'b1;
        cmd.sift_start_root = 1'b1;
      end
      ST_CAT_SKIP: cmd.cat_step = 1'b1;
      ST_OUT: res_load = !out_busy;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP_WAIT |=> state_r == ST_POP_ADV)
    else $error("pop sequence broken");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |=> state_r == ST_IDLE)
    else $error("load not single cycle");
endmodule

// File: rtl/khm_dp.sv
`timescale 1ns / 1ps
module khm_dp import khm_pkg::*; #(
  parameter int MAX_RUNS      = MAX_RUNS_DEF,
  parameter int RUN_DEPTH     = RUN_DEPTH_DEF,
  parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [RUN_SEL_W-1:0] in_run_sel,
  input  logic [KEY_WIDTH-1:0] in_row_key,
  input  logic [PAYLOAD_WIDTH-1:0] in_row_payload,
  input  logic                 cfg_fire,
  input  logic                 cfg_data,
  input  logic                 res_load,
  input  khm_cmd_t             cmd,
  output khm_sts_t             sts,
  output logic [OUT_W-1:0]     res_key,
  output logic [OUT_W-1:0]     res_payload,
  output logic                 res_valid,
  output logic                 res_last
);
  localparam int RW = $clog2(MAX_RUNS);
  localparam int DW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int LW = $clog2(RUN_DEPTH + 1);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int AW = $clog2(MAX_RUNS * RUN_DEPTH);
  localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

  logic [LW-1:0] len_r [MAX_RUNS];
  logic [LW-1:0] cur_r [MAX_RUNS];
  logic [RW-1:0] slot_r [MAX_RUNS];
  logic [CW-1:0] cnt_r;
  logic          started_r, mode_r;
  logic [CW-1:0] cat_r;
  logic [CW-1:0] scan_r, bidx_r, pos_r;
  logic [KEY_WIDTH-1:0] kp_r;
  logic [1:0]    rd_ph_r;

  // latched load fields
  logic [RW-1:0]          ld_run_r;
  logic                   ld_inrange_r;
  logic [KEY_WIDTH-1:0]   ld_key_r;
  logic [PAYLOAD_WIDTH-1:0] ld_pay_r;

  // single-port-read row store; read address muxed by phase
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  khm_ram #(.WIDTH(EW), .DEPTH(MAX_RUNS * RUN_DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] row_addr(input logic [RW-1:0] run,
                                             input logic [LW-1:0] idx);
    logic [AW+LW-1:0] a;
    a = (AW + LW)'(run) * (AW + LW)'(RUN_DEPTH) + (AW + LW)'(idx);
    return a[AW-1:0];
  endfunction

  logic [CW-1:0] lch, rch;
  logic [RW-1:0] pop_run;
  logic [RW-1:0] cat_run;
  logic [RW-1:0] len_run_sel;
  assign lch = CW'((2 * pos_r) + 1);
  assign rch = CW'((2 * pos_r) + 2);
  assign pop_run = slot_r[0];
  assign cat_run = cat_r[RW-1:0];

  // sift: rd_ph 0 read pos, 1 read left, 2 read right
  logic [CW-1:0] rd_slot;
  always_comb begin
    case (rd_ph_r)
      2'd0: rd_slot = pos_r;
      2'd1: rd_slot = lch;
      default: rd_slot = rch;
    endcase
  end
  logic [RW-1:0] rd_run;
  assign rd_run = slot_r[rd_slot[RW-1:0]];

  always_comb begin
    if (cmd.pop_rd) raddr = row_addr(pop_run, cur_r[pop_run]);
    else if (!mode_r || cmd.cat_step) raddr = row_addr(cat_run, cur_r[cat_run]);
    else raddr = row_addr(rd_run, cur_r[rd_run]);
  end

  assign we    = cmd.load_wr && sts.load_ok;
  assign waddr = row_addr(ld_run_r, len_r[ld_run_r]);
  assign wdata = {ld_key_r, ld_pay_r};
  assign len_run_sel = ld_run_r;

  assign sts.load_ok    = !started_r && ld_inrange_r &&
                          len_r[len_run_sel] < LW'(RUN_DEPTH);
  assign sts.scan_done  = scan_r == CW'(MAX_RUNS);
  assign sts.build_done = bidx_r == '0;
  assign sts.heap_empty = cnt_r == '0;
  assign sts.cat_done   = cat_r == CW'(MAX_RUNS) || cur_r[cat_run] < len_r[cat_run];
  assign sts.cat_ok     = cat_r != CW'(MAX_RUNS);
  assign sts.mode_cmp   = mode_r;
  assign sts.started    = started_r;
  // sift step finished: no left child, or the swap phase found no smaller child
  logic sift_stop_r;
  assign sts.sift_done  = lch >= cnt_r || sift_stop_r;

  // rows left after the one being delivered in concatenation mode
  logic cat_more;
  always_comb begin
    cat_more = cur_r[cat_run] + 1'b1 < len_r[cat_run];
    for (int j = 0; j < MAX_RUNS; j++) begin
      if (CW'(j) > cat_r && cur_r[j] < len_r[j]) cat_more = 1'b1;
    end
  end

  logic [KEY_WIDTH-1:0] rkey;
  assign rkey = rdata[EW-1:PAYLOAD_WIDTH];
  logic [CW-1:0] m_r;

  logic [KEY_WIDTH-1:0] cat_key_r;
  logic [PAYLOAD_WIDTH-1:0] cat_pay_r;
  logic                    pend_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ld_run_r     <= in_run_sel[RW-1:0];
      ld_inrange_r <= 32'(in_run_sel) < MAX_RUNS;
      ld_key_r     <= in_row_key;
      ld_pay_r     <= in_row_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
        len_r[i] <= '0;
        cur_r[i] <= '0;
      end
      cnt_r       <= '0;
      started_r   <= 1'b0;
      mode_r      <= 1'b1;
      cat_r       <= '0;
      scan_r      <= '0;
      bidx_r      <= '0;
      pos_r       <= '0;
      rd_ph_r     <= '0;
      sift_stop_r <= 1'b0;
      pend_r      <= 1'b0;
      res_valid   <= 1'b0;
      res_last    <= 1'b0;
      m_r         <= '0;
    end else begin
      if (cfg_fire && !started_r) mode_r <= cfg_data;
      if (we) len_r[ld_run_r] <= len_r[ld_run_r] + 1'b1;
      if (cmd.start_merge) begin
        started_r <= 1'b1;
        cnt_r     <= '0;
        scan_r    <= '0;
        cat_r     <= '0;
      end
      if (cmd.scan_step && !sts.scan_done) begin
        if (len_r[scan_r[RW-1:0]] != '0) begin
          slot_r[cnt_r[RW-1:0]] <= scan_r[RW-1:0];
          cnt_r <= cnt_r + 1'b1;
        end
        scan_r <= scan_r + 1'b1;
        if (scan_r == CW'(MAX_RUNS - 1)) bidx_r <= '0;
      end
      if (cmd.sift_start_build) begin
        pos_r       <= (cmd.scan_step ? (cnt_r >> 1) : bidx_r) - 1'b1;
        bidx_r      <= (cmd.scan_step ? (cnt_r >> 1) : bidx_r) - 1'b1;
        rd_ph_r     <= '0;
        sift_stop_r <= 1'b0;
      end
      // up to three reads (right child only if present) then a swap step, each in a SIFT_RD then SIFT_CMP state pair
      if (cmd.sift_cmp) begin
        case (rd_ph_r)
          2'd0: begin
            kp_r <= rkey;
            m_r  <= pos_r;
            rd_ph_r <= 2'd1;
          end
          2'd1: begin
            if (rkey < kp_r) begin
              kp_r <= rkey;
              m_r  <= lch;
            end
            if (rch < cnt_r) rd_ph_r <= 2'd2;
            else rd_ph_r <= 2'd3;
          end
          2'd2: begin
            if (rkey < kp_r) m_r <= rch;
            rd_ph_r <= 2'd3;
          end
          default: begin
            if (m_r == pos_r) begin
              sift_stop_r <= 1'b1;
            end else begin
              slot_r[m_r[RW-1:0]]   <= slot_r[pos_r[RW-1:0]];
              slot_r[pos_r[RW-1:0]] <= slot_r[m_r[RW-1:0]];
              pos_r   <= m_r;
            end
            rd_ph_r <= 2'd0;
          end
        endcase
      end
      if (cmd.pop_rd && cnt_r != '0) pend_r <= 1'b1;
      if (cmd.pop_rd && cnt_r == '0) pend_r <= 1'b0;
      if (cmd.pop_adv) begin
        cat_key_r <= rkey;
        cat_pay_r <= rdata[PAYLOAD_WIDTH-1:0];
        cur_r[pop_run] <= cur_r[pop_run] + 1'b1;
        pos_r       <= '0;
        rd_ph_r     <= '0;
        sift_stop_r <= 1'b0;
        if (cur_r[pop_run] + 1'b1 >= len_r[pop_run]) begin
          slot_r[0] <= slot_r[RW'(cnt_r - 1'b1)];
          cnt_r     <= cnt_r - 1'b1;
        end
      end
      if (cmd.cat_step && !sts.cat_done) cat_r <= cat_r + 1'b1;
      if (res_load) begin
        if (mode_r) begin
          res_valid <= pend_r;
          res_last  <= pend_r && cnt_r == '0;
          pend_r    <= 1'b0;
        end
      end
      if (!mode_r && res_load) begin
        res_valid <= sts.cat_ok;
        res_last  <= sts.cat_ok && !cat_more;
        if (sts.cat_ok) cur_r[cat_run] <= cur_r[cat_run] + 1'b1;
      end
    end
  end

  // concat-mode delivery and the heap-mode row/zero result
  always_ff @(posedge clk) begin
    if (res_load) begin
      if (mode_r) begin
        res_key     <= pend_r ? OUT_W'(cat_key_r) : '0;
        res_payload <= pend_r ? OUT_W'(cat_pay_r) : '0;
      end else begin
        res_key     <= sts.cat_ok ? OUT_W'(rkey) : '0;
        res_payload <= sts.cat_ok ? OUT_W'(rdata[PAYLOAD_WIDTH-1:0]) : '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RUNS))
    else $error("heap count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("merge start dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> $stable(mode_r))
    else $error("mode changed after start");
endmodule

// File: rtl/kway_heap_merge.sv
`timescale 1ns / 1ps
// kway_heap_merge: k-way merge of presorted runs through a binary min-heap.
// in channel: cmd 0 appends row_key/row_payload to run run_sel, cmd 1 pulls
// the next merged row. Every pull yields exactly one item on the out
// channel; loads yield nothing. out_out_valid 0 means all runs were
// exhausted, out_last marks the final row.
// cfg channel: one bit, compare_enable (reset 1); ignored once merging began.
// A pull in heap mode reads the root row, then sifts down about
// log2(MAX_RUNS) levels, each level taking up to four read and compare
// steps on the single read port (parent, left, right, swap). The first
// pull also scans the run lengths and heapifies. Concatenation pulls
// step past each finished or empty run in turn.
// One item is in flight at a time.
// Reset (synchronous, rst_n low) clears run lengths, cursors and the heap;
// row store contents are left as they are.
// A stalled receiver holds the result register; one more item is taken,
// but its result waits and in_ready stays low until the register frees.
module kway_heap_merge import khm_pkg::*; #(
  parameter int MAX_RUNS      = MAX_RUNS_DEF,
  parameter int RUN_DEPTH     = RUN_DEPTH_DEF,
  parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [RUN_SEL_W-1:0]     in_run_sel,
  input  logic [KEY_WIDTH-1:0]     in_row_key,
  input  logic [PAYLOAD_WIDTH-1:0] in_row_payload,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_W-1:0]         out_key,
  output logic [OUT_W-1:0]         out_payload,
  output logic                     out_out_valid,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_compare_enable
);
  khm_cmd_t cmd;
  khm_sts_t sts;
  logic     in_fire, res_load, out_full_r;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  khm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(in_cmd),
    .out_busy(out_full_r && !out_ready), .in_ready(in_ready),
    .res_load(res_load), .cmd(cmd), .sts(sts)
  );

  khm_dp #(
    .MAX_RUNS(MAX_RUNS), .RUN_DEPTH(RUN_DEPTH),
    .KEY_WIDTH(KEY_WIDTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_run_sel(in_run_sel),
    .in_row_key(in_row_key), .in_row_payload(in_row_payload),
    .cfg_fire(cfg_valid), .cfg_data(cfg_compare_enable),
    .res_load(res_load), .cmd(cmd), .sts(sts),
    .res_key(out_key), .res_payload(out_payload),
    .res_valid(out_out_valid), .res_last(out_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (res_load) begin
      out_full_r <= 1'b1;
    end else if (out_ready) begin
      out_full_r <= 1'b0;
    end
  end
  assign out_valid = out_full_r;
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import khm_pkg::*;

  localparam int NRUN = MAX_RUNS_DEF;
  localparam int DEPTH = RUN_DEPTH_DEF;
  localparam int RAND_LOADS = 860;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
    logic        row_valid;
    logic        last;
  } row_t;

  typedef struct {
    logic                 cmd;
    logic [RUN_SEL_W-1:0] run;
    logic [31:0]          key;
    logic [31:0]          payload;
  } load_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  khm_if #(.W(1 + RUN_SEL_W + 64)) in_ch ();
  khm_if #(.W(66)) out_ch ();
  khm_if #(.W(1)) cfg_ch ();

  kway_heap_merge dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_cmd             (in_ch.data[RUN_SEL_W+64]),
    .in_run_sel         (in_ch.data[RUN_SEL_W+63:64]),
    .in_row_key         (in_ch.data[63:32]),
    .in_row_payload     (in_ch.data[31:0]),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_key            (out_ch.data[65:34]),
    .out_payload        (out_ch.data[33:2]),
    .out_out_valid      (out_ch.data[1]),
    .out_last           (out_ch.data[0]),
    .cfg_valid          (cfg_ch.valid),
    .cfg_ready          (cfg_ch.ready),
    .cfg_compare_enable (cfg_ch.data[0])
  );

  // merge state mirror
  logic [31:0] row_keys [NRUN][DEPTH];
  logic [31:0] row_pays [NRUN][DEPTH];
  int          run_len [NRUN];
  int          run_pos [NRUN];
  int          heap_run [NRUN];
  int          heap_size;
  bit          merging;
  int          cat_run;
  bit          by_key;

  row_t expected_rows [$];
  int   mismatches = 0;
  int   rows_checked = 0;
  int   loads_taken = 0;
  int   pulls_taken = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  bit   hold_req = 0;
  bit   hold_active = 0;

  function automatic logic [31:0] head_of(int slot);
    return row_keys[heap_run[slot]][run_pos[heap_run[slot]]];
  endfunction

  function automatic void sift_heap(int pos);
    int l;
    int m;
    int t;
    forever begin
      l = 2 * pos + 1;
      m = pos;
      if (l >= heap_size) return;
      if (head_of(l) < head_of(m)) m = l;
      if (l + 1 < heap_size && head_of(l + 1) < head_of(m)) m = l + 1;
      if (m == pos) return;
      t = heap_run[m];
      heap_run[m] = heap_run[pos];
      heap_run[pos] = t;
      pos = m;
    end
  endfunction

  function automatic void skip_drained();
    while (cat_run < NRUN && run_pos[cat_run] >= run_len[cat_run]) cat_run++;
  endfunction

  function automatic row_t next_merged_row();
    row_t r;
    int run;
    int at;
    r = '0;
    if (!merging) begin
      merging = 1;
      cat_run = 0;
      heap_size = 0;
      if (by_key) begin
        for (int i = 0; i < NRUN; i++)
          if (run_len[i] > 0) heap_run[heap_size++] = i;
        for (int i = heap_size / 2; i > 0; i--) sift_heap(i - 1);
      end else begin
        skip_drained();
      end
    end
    if (by_key) begin
      if (heap_size == 0) return r;
      run = heap_run[0];
      at = run_pos[run]++;
      if (run_pos[run] >= run_len[run]) begin
        heap_run[0] = heap_run[heap_size - 1];
        heap_size--;
      end
      if (heap_size > 0) sift_heap(0);
      r.last = (heap_size == 0);
    end else begin
      if (cat_run >= NRUN) return r;
      run = cat_run;
      at = run_pos[run]++;
      skip_drained();
      r.last = (cat_run >= NRUN);
    end
    r.key = row_keys[run][at];
    r.payload = row_pays[run][at];
    r.row_valid = 1'b1;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NRUN; i++) begin
      run_len[i] = 0;
      run_pos[i] = 0;
    end
    heap_size = 0;
    merging = 0;
    cat_run = 0;
    by_key = 1;
  end

  // predict on every accepted item and config write
  always @(posedge clk) begin
    logic [RUN_SEL_W-1:0] rs;
    if (rst_n && cfg_ch.valid && cfg_ch.ready && !merging) by_key = cfg_ch.data[0];
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rs = in_ch.data[RUN_SEL_W+63:64];
      if (in_ch.data[RUN_SEL_W+64] == CMD_PULL) begin
        expected_rows.push_back(next_merged_row());
        pulls_taken++;
      end else begin
        loads_taken++;
        if (!merging && run_len[rs] < DEPTH) begin
          row_keys[rs][run_len[rs]] = in_ch.data[63:32];
          row_pays[rs][run_len[rs]] = in_ch.data[31:0];
          run_len[rs]++;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    row_t got;
    row_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row key", got.key, 32'h0000_0000);
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (got.key !== want.key) report_mismatch("out_key", got.key, want.key);
        if (got.payload !== want.payload)
          report_mismatch("out_payload", got.payload, want.payload);
        if (got.row_valid !== want.row_valid)
          report_mismatch("out_out_valid", 32'(got.row_valid), 32'(want.row_valid));
        if (got.last !== want.last)
          report_mismatch("out_last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_active) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 0;
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic cmd, logic [RUN_SEL_W-1:0] run, logic [31:0] key,
                           logic [31:0] payload);
    in_ch.valid <= 1'b1;
    in_ch.data <= {cmd, run, key, payload};
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_mode(logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_phase(int ph);
    case (ph % 4)
      0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      1: begin snd_idle_pct = 74; rcv_stall_pct = 0; end
      2: begin snd_idle_pct = 0; rcv_stall_pct = 74; end
      default: begin snd_idle_pct = 23; rcv_stall_pct = 23; end
    endcase
  endtask

  // extremes of key and payload, ties across runs, every run selector
  load_row_t directed_loads [13] = '{
    '{CMD_LOAD, 3'd0, 32'h0000_0000, 32'h0000_0000},
    '{CMD_LOAD, 3'd0, 32'h0000_0005, 32'hFFFF_FFFF},
    '{CMD_LOAD, 3'd1, 32'h0000_0005, 32'h1111_1111},
    '{CMD_LOAD, 3'd2, 32'h0000_0005, 32'h2222_2222},
    '{CMD_LOAD, 3'd2, 32'h0000_0005, 32'h2222_2223},
    '{CMD_LOAD, 3'd7, 32'h0000_0001, 32'hA5A5_A5A5},
    '{CMD_LOAD, 3'd7, 32'hFFFF_FFFF, 32'h5A5A_5A5A},
    '{CMD_LOAD, 3'd4, 32'h7FFF_FFFF, 32'h8000_0000},
    '{CMD_LOAD, 3'd4, 32'h8000_0000, 32'h7FFF_FFFF},
    '{CMD_LOAD, 3'd5, 32'h0000_0000, 32'hFFFF_FFFF},
    '{CMD_LOAD, 3'd6, 32'hFFFF_FFFF, 32'h0000_0000},
    '{CMD_LOAD, 3'd3, 32'h0000_0002, 32'h3333_3333},
    '{CMD_LOAD, 3'd1, 32'h0000_0006, 32'h1111_1112}
  };

  logic [31:0] last_key [NRUN];
  int total_rows;
  int pull_count;
  logic [RUN_SEL_W-1:0] rs;
  logic [31:0] k;
  int sel;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b0);
    write_mode(1'b1);

    foreach (directed_loads[i])
      send_item(directed_loads[i].cmd, directed_loads[i].run, directed_loads[i].key,
                directed_loads[i].payload);
    for (int i = 0; i < NRUN; i++) last_key[i] = $urandom_range(0, 1 << 20);

    // mostly ascending runs with ties, some unordered noise; run 3 overfills
    for (int i = 0; i < RAND_LOADS; i++) begin
      set_phase(i * 4 / RAND_LOADS);
      sel = $urandom_range(0, 11);
      rs = (sel >= NRUN) ? 3'd3 : sel[RUN_SEL_W-1:0];
      if ($urandom_range(0, 99) < 15) begin
        k = $urandom;
      end else begin
        k = last_key[rs];
        if ($urandom_range(0, 3) != 0 && k < 32'hFFF0_0000) k = k + $urandom_range(1, 1 << 16);
        last_key[rs] = k;
      end
      send_item(CMD_LOAD, rs, k, $urandom);
    end
    settle();

    write_mode(1'b0);
    write_mode(1'b1);
    write_mode(1'($urandom_range(0, 1)));

    total_rows = 0;
    for (int i = 0; i < NRUN; i++) total_rows += run_len[i];
    pull_count = total_rows + 4;
    for (int i = 0; i < pull_count; i++) begin
      set_phase(i * 4 / pull_count + 1);
      if (i == 100) hold_req = 1;
      if (i == 20) begin
        // mode writes and loads once merging has begun are dropped
        settle();
        write_mode(~by_key);
        send_item(CMD_LOAD, 3'd6, 32'h0000_0000, 32'hDEAD_BEEF);
        send_item(CMD_LOAD, 3'd0, $urandom, $urandom);
      end
      send_item(CMD_PULL, RUN_SEL_W'($urandom), $urandom, $urandom);
    end
    settle();

    $display("merged %0d rows in %s mode from %0d loads, %0d pulls, %0d results checked",
             total_rows, by_key ? "heap" : "concatenation", loads_taken, pulls_taken,
             rows_checked);
    $display("covered full-run drops, late loads and mode writes, pulls past the end");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/khm_pkg.sv
rtl/khm_if.sv
rtl/khm_ram.sv
rtl/khm_ctrl.sv
rtl/khm_dp.sv
rtl/kway_heap_merge.sv
test/testbench.sv
